FILE: hw/rtl/fwm_pkg.sv
// Shared types, character codes and helper functions for the filename
// wildcard matcher. Used by fwm_cell and filename_wildcard_matcher_unit.
`timescale 1ns / 1ps

package fwm_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_NAME   = 2'd2,
    OP_END    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_EMPTY = 2'd0,
    KIND_DOTS  = 2'd1,
    KIND_OTHER = 2'd2
  } prefix_kind_t;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_GRAPH_LO = 8'h21;
  localparam logic [7:0] CH_GRAPH_HI = 8'h7E;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // Control broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic       step;    // a name character advances the active set
    logic       append;  // a pattern character is written at the fill point
    logic       clear;   // the pattern is emptied
    logic       fresh;   // active set is the star prefix of the pattern
    logic [7:0] sym;     // raw input byte
    logic [7:0] nfold;   // input byte with letter case folded
  } fwm_ctl_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

  function automatic logic is_graphic(input logic [7:0] c);
    return (c >= CH_GRAPH_LO) && (c <= CH_GRAPH_HI);
  endfunction

endpackage

FILE: hw/rtl/fwm_cell.sv
// One pattern position of the matcher chain: stored character, star-prefix
// bit and active bit. Depends on fwm_pkg.
`timescale 1ns / 1ps

module fwm_cell #(
  parameter int IDX = 0,
  parameter int LW  = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  fwm_pkg::fwm_ctl_t ctl,
  input  logic [LW-1:0]   len,
  input  logic            adv_in,
  input  logic            clo_in,
  input  logic            sp_in,
  output logic            adv_out,
  output logic            clo_out,
  output logic            sp_out,
  output logic            cur
);

  logic [7:0] pch;
  logic       is_star;
  logic       is_q;
  logic       is_gr;
  logic       sp;
  logic       act;
  logic       used;
  logic       here;
  logic       self_loop;
  logic       act_next;

  assign used = len > LW'(IDX);
  assign here = len == LW'(IDX);

  // Position is active either from the last step or, right after a restart,
  // when every pattern character in front of it is a star.
  assign cur = ctl.fresh ? sp_in : act;

  assign self_loop = cur & used & is_star;
  assign adv_out   = ctl.step & cur & used & ~is_star & is_gr &
                     (is_q | (pch == ctl.nfold));
  assign act_next  = (ctl.step & self_loop) | adv_in | clo_in;
  assign clo_out   = act_next & used & is_star;
  assign sp_out    = sp;

  always_ff @(posedge clk) begin
    if (ctl.append && here) begin
      pch     <= fwm_pkg::fold_case(ctl.sym);
      is_star <= ctl.sym == fwm_pkg::CH_STAR;
      is_q    <= ctl.sym == fwm_pkg::CH_QUEST;
      is_gr   <= fwm_pkg::is_graphic(ctl.sym);
    end
    if (ctl.step) begin
      act <= act_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      sp <= 1'b0;
    end else if (ctl.append && here) begin
      sp <= sp_in & (ctl.sym == fwm_pkg::CH_STAR);
    end
  end

endmodule

FILE: hw/rtl/filename_wildcard_matcher_unit.sv
// Top level of the filename wildcard matcher: control, name tracking,
// result register and the chain of fwm_cell instances. Depends on fwm_pkg.
`timescale 1ns / 1ps

// Channel  Signals                               Direction  Item
// -------  ------------------------------------  ---------  ------------------------
// in       in_valid, in_stall, opcode, symbol    sink       command or character
// out      out_valid, out_stall, matched,        source     one per end of name
//          pattern_overflow
//
// One item is taken every cycle unless the input is stalled. The critical path is the
// star closure, which ripples through the cell chain (one OR/AND per pattern position)
// after the per-cell character compare.
// The result of an end-of-name item appears in the output register on the
// next cycle. Input is stalled only while that register is full and stalled.
// Reset (synchronous, rst high) empties the pattern, clears overflow and
// drops any pending result; the pattern character store is not cleared.

module filename_wildcard_matcher_unit #(
  parameter int MAX_PATTERN = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [7:0] symbol,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       matched,
  output logic       pattern_overflow
);

  localparam int LW = $clog2(MAX_PATTERN + 1);

  // Pattern and name state.
  logic [LW-1:0]         len;
  logic                  ovf;
  logic                  fresh;
  logic                  name_invalid;
  fwm_pkg::prefix_kind_t kind;
  logic [1:0]            name_count;
  logic                  act_last;

  fwm_pkg::fwm_ctl_t ctl;

  // Chain wiring. Index i of cur_v and sp_v is pattern position i.
  logic [MAX_PATTERN-1:0] adv;
  logic [MAX_PATTERN-1:0] clo;
  logic [MAX_PATTERN:0]   sp_v;
  logic [MAX_PATTERN:0]   cur_v;
  logic                   act_last_next;

  logic accept;
  logic op_clear;
  logic op_append;
  logic op_name;
  logic op_end;
  logic restart;
  logic name_bad;
  logic is_dot_name;
  logic all_star;
  logic match_now;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign op_clear  = accept && (fwm_pkg::opcode_t'(opcode) == fwm_pkg::OP_CLEAR);
  assign op_append = accept && (fwm_pkg::opcode_t'(opcode) == fwm_pkg::OP_APPEND);
  assign op_name   = accept && (fwm_pkg::opcode_t'(opcode) == fwm_pkg::OP_NAME);
  assign op_end    = accept && (fwm_pkg::opcode_t'(opcode) == fwm_pkg::OP_END);
  assign restart   = op_clear | op_append | op_end;

  always_comb begin
    ctl.step   = op_name;
    // A full pattern drops further characters, so nothing is written then.
    ctl.append = op_append && (len < LW'(MAX_PATTERN));
    ctl.clear  = op_clear;
    ctl.fresh  = fresh;
    ctl.sym    = symbol;
    ctl.nfold  = fwm_pkg::fold_case(symbol);
  end

  // Position zero is always the start of the star prefix.
  assign sp_v[0] = 1'b1;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    if (i == 0) begin : g_first
      fwm_cell #(.IDX(i), .LW(LW)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctl     (ctl),
        .len     (len),
        .adv_in  (1'b0),
        .clo_in  (1'b0),
        .sp_in   (sp_v[i]),
        .adv_out (adv[i]),
        .clo_out (clo[i]),
        .sp_out  (sp_v[i+1]),
        .cur     (cur_v[i])
      );
    end else begin : g_rest
      fwm_cell #(.IDX(i), .LW(LW)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctl     (ctl),
        .len     (len),
        .adv_in  (adv[i-1]),
        .clo_in  (clo[i-1]),
        .sp_in   (sp_v[i]),
        .adv_out (adv[i]),
        .clo_out (clo[i]),
        .sp_out  (sp_v[i+1]),
        .cur     (cur_v[i])
      );
    end
  end

  // The position past the last cell is only reachable with a full pattern.
  assign cur_v[MAX_PATTERN] = fresh ? sp_v[MAX_PATTERN] : act_last;
  assign act_last_next      = adv[MAX_PATTERN-1] | clo[MAX_PATTERN-1];

  // A name character that is not graphic, or is itself a wildcard, spoils
  // the name.
  assign name_bad = ~fwm_pkg::is_graphic(symbol) || (symbol == fwm_pkg::CH_STAR) ||
                    (symbol == fwm_pkg::CH_QUEST);

  // Result of the current name, valid when an end-of-name item is taken.
  assign is_dot_name = (kind == fwm_pkg::KIND_DOTS) &&
                       ((name_count == 2'd1) || (name_count == 2'd2));
  assign all_star    = ((len == LW'(1)) && sp_v[1]) || ((len == LW'(2)) && sp_v[2]);

  always_comb begin
    priority if (ovf || is_dot_name) begin
      match_now = 1'b0;
    end else if (all_star) begin
      match_now = 1'b1;
    end else if (name_invalid) begin
      match_now = 1'b0;
    end else begin
      match_now = cur_v[len];
    end
  end

  // Pattern length and overflow.
  always_ff @(posedge clk) begin
    if (rst || op_clear) begin
      len <= '0;
      ovf <= 1'b0;
    end else if (op_append) begin
      if (len < LW'(MAX_PATTERN)) begin
        len <= LW'(len + 1'b1);
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  // Name tracking. Any pattern change or end of name starts a new name.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      fresh        <= 1'b1;
      name_invalid <= 1'b0;
      kind         <= fwm_pkg::KIND_EMPTY;
      name_count   <= 2'd0;
    end else if (op_name) begin
      fresh <= 1'b0;
      if (name_bad) begin
        name_invalid <= 1'b1;
      end
      if (name_count != 2'd3) begin
        name_count <= name_count + 2'd1;
      end
      if (symbol == fwm_pkg::CH_DOT && kind != fwm_pkg::KIND_OTHER) begin
        kind <= fwm_pkg::KIND_DOTS;
      end else begin
        kind <= fwm_pkg::KIND_OTHER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_name) begin
      act_last <= act_last_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op_end) begin
      matched          <= match_now;
      pattern_overflow <= ovf;
    end
  end

  // An end-of-name item always leaves a result in the output register.
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    op_end |=> out_valid)
    else $error("end of name did not produce a result");

  // An overflowed pattern never reports a match.
  a_overflow_no_match: assert property (@(posedge clk) disable iff (rst)
    (op_end && ovf) |=> (pattern_overflow && !matched))
    else $error("overflowed pattern reported a match");

  // Input is held back only while a result waits.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  // Clearing the pattern empties it and restarts the name.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    op_clear |=> (len == '0 && !ovf && fresh))
    else $error("clear did not empty the pattern");

endmodule

FILE: tb/name_match_checker.sv
// Checker for the filename wildcard matcher: watches both channels, keeps its own
// copy of the pattern and the active-position set, and compares every result.
// Depends on fwm_pkg for the opcode and prefix-kind enums and the character codes.
`timescale 1ns / 1ps

module name_match_checker #(
  parameter int MAX_PATTERN = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [7:0] symbol,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       matched,
  input  logic       pattern_overflow,
  output int         error_count,
  output int         results_owed,
  output int         results_checked,
  output int         match_count,
  output int         overflow_count
);

  typedef struct packed {
    logic matched;
    logic overflow;
  } name_result_t;

  name_result_t          owed_results[$];

  logic [7:0]            pat_chars [MAX_PATTERN];
  int unsigned           pat_len;
  logic                  pat_overflow;
  logic [MAX_PATTERN:0]  live_pos;
  logic                  name_bad;
  fwm_pkg::prefix_kind_t name_kind;
  logic [1:0]            name_len;

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    if (c < fwm_pkg::CH_UPPER_A || c > fwm_pkg::CH_UPPER_Z) return c;
    return c + fwm_pkg::CASE_OFFSET;
  endfunction

  function automatic logic printable(input logic [7:0] c);
    return !(c < fwm_pkg::CH_GRAPH_LO || c > fwm_pkg::CH_GRAPH_HI);
  endfunction

  // Every set position that sits in front of a star also enables the one after it.
  function automatic logic [MAX_PATTERN:0] expand_stars(input logic [MAX_PATTERN:0] v);
    for (int i = 0; i < pat_len; i++) begin
      if (v[i] && pat_chars[i] == fwm_pkg::CH_STAR) v[i + 1] = 1'b1;
    end
    return v;
  endfunction

  task automatic start_name();
    live_pos = expand_stars({{MAX_PATTERN{1'b0}}, 1'b1});
    name_bad = 1'b0;
    name_kind = fwm_pkg::KIND_EMPTY;
    name_len = 2'd0;
  endtask

  task automatic advance_name(input logic [7:0] c);
    logic [MAX_PATTERN:0] nxt;
    logic [7:0]           lc;
    logic [7:0]           p;
    nxt = '0;
    lc = lower_ascii(c);
    if (!printable(c) || c == fwm_pkg::CH_QUEST || c == fwm_pkg::CH_STAR) name_bad = 1'b1;
    if (name_len != 2'd3) name_len++;
    name_kind = (c == fwm_pkg::CH_DOT && name_kind != fwm_pkg::KIND_OTHER) ?
                fwm_pkg::KIND_DOTS : fwm_pkg::KIND_OTHER;
    for (int i = 0; i < pat_len; i++) begin
      p = pat_chars[i];
      if (live_pos[i]) begin
        if (p == fwm_pkg::CH_STAR) nxt[i] = 1'b1;
        else if (printable(p) && (p == fwm_pkg::CH_QUEST || lower_ascii(p) == lc))
          nxt[i + 1] = 1'b1;
      end
    end
    live_pos = expand_stars(nxt);
  endtask

  function automatic name_result_t judge_name();
    name_result_t r;
    logic         only_stars;
    only_stars = (pat_len == 1 && pat_chars[0] == fwm_pkg::CH_STAR) ||
                 (pat_len == 2 && pat_chars[0] == fwm_pkg::CH_STAR &&
                  pat_chars[1] == fwm_pkg::CH_STAR);
    r.overflow = pat_overflow;
    if (pat_overflow) r.matched = 1'b0;
    else if (name_kind == fwm_pkg::KIND_DOTS && (name_len == 2'd1 || name_len == 2'd2))
      r.matched = 1'b0;
    else if (only_stars) r.matched = 1'b1;
    else if (name_bad) r.matched = 1'b0;
    else r.matched = live_pos[pat_len];
    return r;
  endfunction

  always @(posedge clk) begin
    name_result_t want;
    if (rst) begin
      owed_results.delete();
      pat_len = 0;
      pat_overflow = 1'b0;
      start_name();
      error_count = 0;
      results_checked = 0;
      match_count = 0;
      overflow_count = 0;
    end else begin
      // A result can never come in the cycle of its own end-of-name item, so
      // the output side is handled first.
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          flag_mismatch($sformatf("result (matched %b, overflow %b) with none owed",
                                  matched, pattern_overflow));
        end else begin
          want = owed_results.pop_front();
          if (matched !== want.matched)
            flag_mismatch($sformatf("result %0d: matched %b, expected %b",
                                    results_checked, matched, want.matched));
          if (pattern_overflow !== want.overflow)
            flag_mismatch($sformatf("result %0d: pattern_overflow %b, expected %b",
                                    results_checked, pattern_overflow, want.overflow));
          results_checked++;
          if (want.matched) match_count++;
          if (want.overflow) overflow_count++;
        end
      end
      if (in_valid && !in_stall) begin
        case (fwm_pkg::opcode_t'(opcode))
          fwm_pkg::OP_CLEAR: begin
            pat_len = 0;
            pat_overflow = 1'b0;
            start_name();
          end
          fwm_pkg::OP_APPEND: begin
            if (pat_len < MAX_PATTERN) begin
              pat_chars[pat_len] = symbol;
              pat_len++;
            end else begin
              pat_overflow = 1'b1;
            end
            start_name();
          end
          fwm_pkg::OP_NAME: advance_name(symbol);
          default: begin
            owed_results.push_back(judge_name());
            start_name();
          end
        endcase
      end
    end
    results_owed = owed_results.size();
  end

endmodule

FILE: tb/testbench.sv
// Top of the filename wildcard matcher testbench: clock, reset, item stimulus,
// receiver stalls and the verdict. Depends on fwm_pkg, name_match_checker and
// filename_wildcard_matcher_unit.
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_PATTERN = 32;
  localparam int RANDOM_ITEMS = 1650;
  // Letters that appear in both cases so that case folding is exercised often.
  localparam string LETTERS = "abcABC";

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] opcode = fwm_pkg::OP_CLEAR;
  logic [7:0] symbol = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       matched;
  logic       pattern_overflow;

  int error_count;
  int results_owed;
  int results_checked;
  int match_count;
  int overflow_count;

  int          items_sent = 0;
  int          burst_left = 0;
  int          longest_pattern = 0;
  logic [7:0]  cur_pattern[$];

  filename_wildcard_matcher_unit #(
    .MAX_PATTERN(MAX_PATTERN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .symbol(symbol),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .matched(matched),
    .pattern_overflow(pattern_overflow)
  );

  // The checker sees exactly what crosses both channels and counts mismatches;
  // this module makes the items and the receiver stalls and decides the verdict.
  name_match_checker #(
    .MAX_PATTERN(MAX_PATTERN)
  ) match_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .symbol(symbol),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .matched(matched),
    .pattern_overflow(pattern_overflow),
    .error_count(error_count),
    .results_owed(results_owed),
    .results_checked(results_checked),
    .match_count(match_count),
    .overflow_count(overflow_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver cycles through four stall behaviors in windows of equal length: no
  // stall at all, light random stall, heavy random stall, and a fixed duty pattern.
  // Because the windows do not line up with the sender's bursts, stalls land
  // on every phase of the matcher's work.
  always @(negedge clk) begin
    int unsigned rx_cycle;
    rx_cycle++;
    case ((rx_cycle / 256) % 4)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 99) < 25);
      2:       out_stall <= ($urandom_range(0, 99) < 75);
      default: out_stall <= ((rx_cycle % 16) < 10);
    endcase
  end

  // Sends one item. The sender runs in bursts of random length; between bursts
  // valid drops for a random gap. New values are driven at the falling edge and
  // the handshake is judged from in_stall as it stood at the rising edge.
  task automatic send_item(input fwm_pkg::opcode_t op, input logic [7:0] ch);
    if (burst_left == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    opcode <= op;
    symbol <= ch;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    burst_left--;
    items_sent++;
  endtask

  task automatic send_text(input fwm_pkg::opcode_t op, input string s);
    for (int i = 0; i < s.len(); i++) send_item(op, s[i]);
  endtask

  // Holds the sender until the checker owes no more results.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] random_letter();
    return LETTERS[$urandom_range(0, LETTERS.len() - 1)];
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
      return c ^ fwm_pkg::CASE_OFFSET;
    return c;
  endfunction

  // Pattern characters lean toward stars, question marks and a small alphabet,
  // so that names built from the pattern have a real chance to match.
  function automatic logic [7:0] pick_pattern_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 28) return fwm_pkg::CH_STAR;
    if (r < 40) return fwm_pkg::CH_QUEST;
    if (r < 80) return random_letter();
    if (r < 90) return 8'($urandom_range(fwm_pkg::CH_GRAPH_LO, fwm_pkg::CH_GRAPH_HI));
    return 8'($urandom_range(0, 255));
  endfunction

  // Name characters include dots, wildcards (which spoil a name) and any byte.
  function automatic logic [7:0] pick_name_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return random_letter();
    if (r < 65) return fwm_pkg::CH_DOT;
    if (r < 72) return 8'($urandom_range(fwm_pkg::CH_GRAPH_LO, fwm_pkg::CH_GRAPH_HI));
    if (r < 76) return $urandom_range(0, 1) ? fwm_pkg::CH_QUEST : fwm_pkg::CH_STAR;
    return 8'($urandom_range(0, 255));
  endfunction

  // Clears the pattern and loads a new one. Most patterns are short; a few fill
  // the store exactly and a few run past it to raise the overflow flag.
  task automatic new_pattern();
    int unsigned r;
    int unsigned len;
    logic [7:0]  c;
    send_item(fwm_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
    cur_pattern.delete();
    r = $urandom_range(0, 99);
    if (r < 8) len = $urandom_range(1, 2);
    else if (r < 70) len = $urandom_range(0, 6);
    else if (r < 88) len = $urandom_range(7, MAX_PATTERN - 1);
    else if (r < 93) len = MAX_PATTERN;
    else len = $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 4);
    for (int k = 0; k < len; k++) begin
      c = (r < 8) ? fwm_pkg::CH_STAR : pick_pattern_char();
      send_item(fwm_pkg::OP_APPEND, c);
      if (cur_pattern.size() < MAX_PATTERN) cur_pattern.push_back(c);
    end
    if (cur_pattern.size() > longest_pattern) longest_pattern = cur_pattern.size();
  endtask

  // Sends one name and its end-of-name item. Names are dot names, names built
  // to follow the current pattern (sometimes with one character spoiled), or
  // random text.
  task automatic send_name();
    logic [7:0]  name_chars[$];
    logic [7:0]  p;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      name_chars.push_back(fwm_pkg::CH_DOT);
    end else if (r < 15) begin
      name_chars.push_back(fwm_pkg::CH_DOT);
      name_chars.push_back(fwm_pkg::CH_DOT);
    end else if (r < 60) begin
      foreach (cur_pattern[i]) begin
        p = cur_pattern[i];
        if (p == fwm_pkg::CH_STAR)
          repeat ($urandom_range(0, 2)) name_chars.push_back(random_letter());
        else if (p == fwm_pkg::CH_QUEST) name_chars.push_back(pick_name_char());
        else name_chars.push_back($urandom_range(0, 1) ? flip_case(p) : p);
      end
      if (name_chars.size() > 0 && $urandom_range(0, 4) == 0)
        name_chars[$urandom_range(0, name_chars.size() - 1)] = pick_name_char();
    end else begin
      repeat ($urandom_range(0, 8)) name_chars.push_back(pick_name_char());
    end
    foreach (name_chars[i]) send_item(fwm_pkg::OP_NAME, name_chars[i]);
    send_item(fwm_pkg::OP_END, 8'($urandom_range(0, 255)));
  endtask

  // A stray item with a random opcode: pattern edits in the middle of a name,
  // end-of-name items with no name, and so on.
  task automatic send_noise();
    fwm_pkg::opcode_t op;
    logic [7:0]       c;
    op = fwm_pkg::opcode_t'($urandom_range(0, 3));
    c = 8'($urandom_range(0, 255));
    send_item(op, c);
    if (op == fwm_pkg::OP_CLEAR) cur_pattern.delete();
    else if (op == fwm_pkg::OP_APPEND && cur_pattern.size() < MAX_PATTERN)
      cur_pattern.push_back(c);
  endtask

  initial begin
    bit drained_once;
    int directed_items;
    int unsigned r;
    drained_once = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. An empty pattern matches the empty name.
    send_item(fwm_pkg::OP_END, 8'h00);
    // With the single-star pattern a lone dot still fails, while bytes that are
    // not graphic are accepted because the all-star rule wins.
    send_item(fwm_pkg::OP_APPEND, fwm_pkg::CH_STAR);
    send_item(fwm_pkg::OP_NAME, fwm_pkg::CH_DOT);
    send_item(fwm_pkg::OP_END, 8'hFF);
    send_item(fwm_pkg::OP_NAME, 8'h00);
    send_item(fwm_pkg::OP_NAME, 8'hFF);
    send_item(fwm_pkg::OP_END, 8'h5A);
    // The double-star pattern matches an empty name.
    send_item(fwm_pkg::OP_APPEND, fwm_pkg::CH_STAR);
    send_item(fwm_pkg::OP_END, 8'h00);
    // Star followed by question mark, with case folding on both sides.
    send_item(fwm_pkg::OP_CLEAR, 8'hFF);
    send_text(fwm_pkg::OP_APPEND, "A?*?");
    send_text(fwm_pkg::OP_NAME, "a~Z");
    send_item(fwm_pkg::OP_END, 8'h00);
    // The two-dot name never matches, and a wildcard inside a name spoils it.
    send_text(fwm_pkg::OP_NAME, "..");
    send_item(fwm_pkg::OP_END, 8'h00);
    send_text(fwm_pkg::OP_NAME, "a?b");
    send_item(fwm_pkg::OP_END, 8'h00);
    // A pattern edit mid-name restarts the name; the delete byte can never be
    // passed, so the now-empty name fails.
    send_item(fwm_pkg::OP_NAME, 8'h71);
    send_item(fwm_pkg::OP_APPEND, 8'h7F);
    send_item(fwm_pkg::OP_END, 8'h00);
    directed_items = items_sent;
    wait_for_results();

    // Random part: mostly well-formed pattern and name sequences, some noise.
    new_pattern();
    while (items_sent < directed_items + RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 20) new_pattern();
      else if (r < 90) send_name();
      else send_noise();
      if (!drained_once && items_sent > directed_items + RANDOM_ITEMS / 2) begin
        wait_for_results();
        drained_once = 1'b1;
      end
    end

    wait_for_results();
    repeat (8) @(negedge clk);

    $display("Run summary: %0d items sent, %0d results checked, %0d matches, %0d overflows.",
             items_sent, results_checked, match_count, overflow_count);
    $display("Longest pattern held: %0d characters; mismatches found: %0d.",
             longest_pattern, error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: a correct run ends far sooner than this.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
